/* rtl/line_edit_buffer_defines.svh */
// ----------------------------------------------------------------------------
// line edit buffer assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_DEFINES_SVH
`define LINE_EDIT_BUFFER_DEFINES_SVH

// same-cycle implication
`define LEB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("line edit buffer assertion failed");

// next-cycle implication
`define LEB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("line edit buffer assertion failed");

`endif

/* rtl/leb_pkg.sv */
// ----------------------------------------------------------------------------
// leb_pkg
// types and constants shared by the line edit buffer modules
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KILL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] ERASE_RST    = 8'd35;
    localparam logic [7:0] KILL_RST     = 8'd64;
    localparam logic [7:0] LINE_END_RST = 8'd10;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } leb_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_line;
        logic       line_empty;
        logic       chars_dropped;
    } leb_out_t;

    typedef struct packed {
        logic [7:0] erase_char;
        logic [7:0] kill_char;
        logic [7:0] line_end_char;
    } leb_cfg_t;

endpackage

/* rtl/line_edit_buffer.sv */
// ----------------------------------------------------------------------------
// line_edit_buffer
// terminal line editor with erase, kill and line end characters
// ----------------------------------------------------------------------------
// Typed characters are taken one per cycle while no line is being read out
// and kept in an on-chip store of LINE_DEPTH characters; erase and kill
// characters are taken in the same way. A line end (or end_of_input) takes
// the block out of input until the line has been read out of the store's
// single read port oldest first, one character a cycle while m_ready stays
// high; an empty line gives one item with line_empty set. Characters beyond
// a full store are dropped and chars_dropped is set on every item of that
// line. The store needs no clearing after reset, and configuration writes
// are taken in any cycle but are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  leb_pkg::leb_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output leb_pkg::leb_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [leb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);

    leb_pkg::leb_cfg_t cfg;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [7:0]        mem_rd_data;

    leb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    leb_line_mem #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    leb_ctrl #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

endmodule

/* rtl/leb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// leb_cfg_regs
// erase, kill and line end character registers with their write port
// ----------------------------------------------------------------------------
module leb_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [leb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data,
    output leb_pkg::leb_cfg_t                cfg_out
);

    leb_pkg::leb_cfg_t cfg_reg;
    leb_pkg::leb_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                leb_pkg::CFG_ERASE:    cfg_next.erase_char    = cfg_data;
                leb_pkg::CFG_KILL:     cfg_next.kill_char     = cfg_data;
                leb_pkg::CFG_LINE_END: cfg_next.line_end_char = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.erase_char    <= leb_pkg::ERASE_RST;
            cfg_reg.kill_char     <= leb_pkg::KILL_RST;
            cfg_reg.line_end_char <= leb_pkg::LINE_END_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/leb_line_mem.sv */
// ----------------------------------------------------------------------------
// leb_line_mem
// character store, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module leb_line_mem #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* rtl/leb_ctrl.sv */
// ----------------------------------------------------------------------------
// leb_ctrl
// edit decode, fill count and line readout sequencer with output register
// ----------------------------------------------------------------------------
module leb_ctrl #(
    parameter int LINE_DEPTH = leb_pkg::LINE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  leb_pkg::leb_cfg_t             cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  leb_pkg::leb_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output leb_pkg::leb_out_t             m_data,
    output logic                          mem_wr_en,
    output logic [$clog2(LINE_DEPTH)-1:0] mem_wr_addr,
    output logic [7:0]                    mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(LINE_DEPTH)-1:0] mem_rd_addr,
    input  logic [7:0]                    mem_rd_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic              state_reg,      state_next;
    logic [CW-1:0]     fill_reg,       fill_next;
    logic              ovf_reg,        ovf_next;
    logic              drop_reg,       drop_next;
    logic [CW-1:0]     rd_idx_reg,     rd_idx_next;
    logic              rd_pending_reg, rd_pending_next;
    logic              rd_last_reg,    rd_last_next;
    logic              m_valid_reg,    m_valid_next;
    leb_pkg::leb_out_t out_reg,        out_next;

    logic out_free;
    logic is_end;
    logic mv;
    logic issue;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_data      = out_reg;
    assign mem_wr_addr = fill_reg[AW-1:0];
    assign mem_wr_data = s_data.in_byte;
    assign mem_rd_addr = rd_idx_reg[AW-1:0];

    assign out_free = !m_valid_reg || m_ready;
    assign is_end   = s_data.end_of_input || (s_data.in_byte == cfg.line_end_char);
    // move read data into the output register, and start the next read
    assign mv       = (state_reg == ST_FLUSH) && rd_pending_reg && out_free;
    assign issue    = (state_reg == ST_FLUSH) && (fill_reg != '0)
                      && (rd_idx_reg != fill_reg) && (!rd_pending_reg || mv);

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        drop_next       = drop_reg;
        rd_idx_next     = rd_idx_reg;
        rd_pending_next = rd_pending_reg;
        rd_last_next    = rd_last_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (is_end) begin
                        state_next  = ST_FLUSH;
                        drop_next   = ovf_reg;
                        ovf_next    = 1'b0;
                        rd_idx_next = '0;
                    end else if (s_data.in_byte == cfg.erase_char) begin
                        if (fill_reg != '0) begin
                            fill_next = fill_reg - CW'(1);
                        end
                    end else if (s_data.in_byte == cfg.kill_char) begin
                        fill_next = '0;
                    end else if (fill_reg < CW'(LINE_DEPTH)) begin
                        mem_wr_en = 1'b1;
                        fill_next = fill_reg + CW'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (fill_reg == '0) begin
                    // empty line gives a single flagged item
                    if (out_free) begin
                        out_next.out_byte      = 8'h00;
                        out_next.last_of_line  = 1'b1;
                        out_next.line_empty    = 1'b1;
                        out_next.chars_dropped = drop_reg;
                        m_valid_next           = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end else begin
                    if (mv) begin
                        out_next.out_byte      = mem_rd_data;
                        out_next.last_of_line  = rd_last_reg;
                        out_next.line_empty    = 1'b0;
                        out_next.chars_dropped = drop_reg;
                        m_valid_next           = 1'b1;
                        rd_pending_next        = 1'b0;
                        if (rd_last_reg) begin
                            state_next = ST_IDLE;
                            fill_next  = '0;
                        end
                    end
                    if (issue) begin
                        mem_rd_en       = 1'b1;
                        rd_idx_next     = rd_idx_reg + CW'(1);
                        rd_pending_next = 1'b1;
                        rd_last_next    = ((rd_idx_reg + CW'(1)) == fill_reg);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
            rd_pending_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
            rd_pending_reg <= rd_pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        drop_reg    <= drop_next;
        rd_idx_reg  <= rd_idx_next;
        rd_last_reg <= rd_last_next;
        out_reg     <= out_next;
    end

endmodule

/* rtl/leb_checker.sv */
// ----------------------------------------------------------------------------
// leb_checker
// port-level checks on the line edit buffer, bound to the top level
// ----------------------------------------------------------------------------
`include "line_edit_buffer_defines.svh"

module leb_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  leb_pkg::leb_out_t             m_data
);

    // a stalled result item holds
    `LEB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // an empty line item is the last of its line and carries a zero byte
    `LEB_ASSERT_NOW(a_empty_form, m_valid && m_data.line_empty,
                    m_data.last_of_line && (m_data.out_byte == 8'h00))

    // no item is taken while a line is still being read out
    `LEB_ASSERT_NOW(a_busy_readout, m_valid && !m_data.last_of_line, !s_ready)

    // a line streams without gaps and keeps its drop flag
    `LEB_ASSERT_NEXT(a_line_stream, m_valid && m_ready && !m_data.last_of_line,
                     m_valid && (m_data.chars_dropped == $past(m_data.chars_dropped)))

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
